// ===== src/cfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_pkg
// Shared codes and the flag bundle that travels along the ALU pipeline.
// ----------------------------------------------------------------------------
package cfpa_pkg;

  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_SUB   = 3'd1;
  localparam logic [2:0] ACT_MUL   = 3'd2;
  localparam logic [2:0] ACT_CDIV  = 3'd3;
  localparam logic [2:0] ACT_RDIV  = 3'd4;
  localparam logic [2:0] ACT_CONJ  = 3'd5;
  localparam logic [2:0] ACT_MODSQ = 3'd6;
  localparam logic [2:0] ACT_CMP   = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int DEN_BITS = 64;

  typedef struct packed {
    logic is_div;
    logic divz;
    logic eq;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } flags_t;

endpackage

// ===== src/cfpa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_in_if / cfpa_out_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface cfpa_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  action;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;
  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cfpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               equal;
  logic        [1:0]  status;
  modport source (output valid, res_re, res_im, equal, status, input ready);
  modport sink   (input valid, res_re, res_im, equal, status, output ready);
endinterface

// ===== src/complex_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Complex fixed-point ALU: add, subtract, multiply, complex and real divide,
// conjugate, squared modulus and compare within a tolerance.
// ----------------------------------------------------------------------------
// The block is a pipeline of cells that takes one item in every cycle while
// the output is not stalled; while a result waits for its transfer, the cells
// fill up and then stop taking items. From its transfer in to its result
// being offered, each item passes one multiplier cell, two setup cells, one
// restoring-division cell per quotient bit (RES_BITS + 1 of them) and the
// output register. Every operation walks the whole chain, so results leave in
// order. The tolerance register may be written only while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu
  import cfpa_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cfpa_in_if.sink     in_ch,
  cfpa_out_if.source  out_ch
);

  localparam int RES_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int QW       = RES_BITS + 1;
  localparam int NW       = 65 + FRAC_BITS;
  localparam int XW       = (NW > DEN_BITS + QW) ? NW : DEN_BITS + QW;

  logic [15:0] tolerance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= 16'd1;
    end else if (cfg_we) begin
      tolerance_r <= cfg_wdata;
    end
  end

  logic               m_valid, m_ready;
  logic        [2:0]  m_action;
  logic signed [31:0] m_a_re, m_a_im, m_b_re, m_b_im;
  logic signed [63:0] m_p [6];

  cfpa_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .in_a_re    (in_ch.a_re),
    .in_a_im    (in_ch.a_im),
    .in_b_re    (in_ch.b_re),
    .in_b_im    (in_ch.b_im),
    .out_valid  (m_valid),
    .out_ready  (m_ready),
    .out_action (m_action),
    .out_a_re   (m_a_re),
    .out_a_im   (m_a_im),
    .out_b_re   (m_b_re),
    .out_b_im   (m_b_im),
    .out_p      (m_p)
  );

  logic                c_valid [QW+1];
  logic                c_ready [QW+1];
  flags_t              c_flags [QW+1];
  logic [XW-1:0]       c_rem_re [QW+1];
  logic [XW-1:0]       c_rem_im [QW+1];
  logic [QW-1:0]       c_q_re [QW+1];
  logic [QW-1:0]       c_q_im [QW+1];
  logic [DEN_BITS-1:0] c_den [QW+1];

  cfpa_setup #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW),
    .XW        (XW)
  ) u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .tolerance  (tolerance_r),
    .in_valid   (m_valid),
    .in_ready   (m_ready),
    .in_action  (m_action),
    .in_a_re    (m_a_re),
    .in_a_im    (m_a_im),
    .in_b_re    (m_b_re),
    .in_b_im    (m_b_im),
    .in_p       (m_p),
    .out_valid  (c_valid[0]),
    .out_ready  (c_ready[0]),
    .out_flags  (c_flags[0]),
    .out_rem_re (c_rem_re[0]),
    .out_rem_im (c_rem_im[0]),
    .out_den    (c_den[0])
  );

  assign c_q_re[0] = '0;
  assign c_q_im[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    cfpa_div_cell #(
      .XW  (XW),
      .QW  (QW),
      .BIT (QW - 1 - k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (c_valid[k]),
      .in_ready   (c_ready[k]),
      .in_flags   (c_flags[k]),
      .in_rem_re  (c_rem_re[k]),
      .in_rem_im  (c_rem_im[k]),
      .in_q_re    (c_q_re[k]),
      .in_q_im    (c_q_im[k]),
      .in_den     (c_den[k]),
      .out_valid  (c_valid[k+1]),
      .out_ready  (c_ready[k+1]),
      .out_flags  (c_flags[k+1]),
      .out_rem_re (c_rem_re[k+1]),
      .out_rem_im (c_rem_im[k+1]),
      .out_q_re   (c_q_re[k+1]),
      .out_q_im   (c_q_im[k+1]),
      .out_den    (c_den[k+1])
    );
  end

  cfpa_out #(
    .XW       (XW),
    .QW       (QW),
    .RES_BITS (RES_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid[QW]),
    .in_ready  (c_ready[QW]),
    .in_flags  (c_flags[QW]),
    .in_rem_re (c_rem_re[QW]),
    .in_rem_im (c_rem_im[QW]),
    .in_q_re   (c_q_re[QW]),
    .in_q_im   (c_q_im[QW]),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/cfpa_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_mult
// First pipeline cell: forms the six 32x32 signed partial products.
// ----------------------------------------------------------------------------
module cfpa_mult
  import cfpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  in_action,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [2:0]  out_action,
  output logic signed [31:0] out_a_re,
  output logic signed [31:0] out_a_im,
  output logic signed [31:0] out_b_re,
  output logic signed [31:0] out_b_im,
  output logic signed [63:0] out_p [6]
);

  logic               valid_r;
  logic        [2:0]  action_r;
  logic signed [31:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [63:0] p_r [6];
  logic signed [31:0] sq_x, sq_y;

  assign in_ready = !valid_r || out_ready;
  assign sq_x = (in_action == ACT_MODSQ) ? in_a_re : in_b_re;
  assign sq_y = (in_action == ACT_MODSQ) ? in_a_im : in_b_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      action_r <= in_action;
      a_re_r   <= in_a_re;
      a_im_r   <= in_a_im;
      b_re_r   <= in_b_re;
      b_im_r   <= in_b_im;
      p_r[0]   <= in_a_re * in_b_re;
      p_r[1]   <= in_a_im * in_b_im;
      p_r[2]   <= in_a_im * in_b_re;
      p_r[3]   <= in_a_re * in_b_im;
      p_r[4]   <= sq_x * sq_x;
      p_r[5]   <= sq_y * sq_y;
    end
  end

  assign out_valid  = valid_r;
  assign out_action = action_r;
  assign out_a_re   = a_re_r;
  assign out_a_im   = a_im_r;
  assign out_b_re   = b_re_r;
  assign out_b_im   = b_im_r;
  assign out_p      = p_r;

endmodule

// ===== src/cfpa_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_setup
// Two pipeline cells: the first combines operands or products into signed sums and
// splits them into sign and magnitude; the second scales the magnitudes and
// flags quotients that cannot fit before the divider cells.
// ----------------------------------------------------------------------------
module cfpa_setup
  import cfpa_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 33,
  parameter int XW        = 97
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic        [15:0] tolerance,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  in_action,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  input  logic signed [63:0] in_p [6],
  output logic               out_valid,
  input  logic               out_ready,
  output flags_t             out_flags,
  output logic [XW-1:0]      out_rem_re,
  output logic [XW-1:0]      out_rem_im,
  output logic [DEN_BITS-1:0] out_den
);

  logic signed [65:0] s_re, s_im;
  logic signed [32:0] d_re, d_im, br_x;
  logic        [32:0] ad_re, ad_im, abs_br;
  logic        [65:0] m_re, m_im;
  logic        [DEN_BITS-1:0] den;
  logic               shift, is_div, divz, eq, neg_re, neg_im;

  logic               v1_r, v2_r, rdy1, rdy2;
  flags_t             f1_r, f2_r;
  logic               shift1_r;
  logic        [64:0] mag_re_r, mag_im_r;
  logic [DEN_BITS-1:0] den1_r, den2_r;
  logic [XW-1:0]      rem_re_r, rem_im_r, r_re, r_im, den_sh;
  flags_t             f2_nxt;

  always_comb begin
    s_re   = '0;
    s_im   = '0;
    shift  = 1'b0;
    is_div = 1'b0;
    divz   = 1'b0;
    den    = '0;
    br_x   = 33'(in_b_re);
    abs_br = unsigned'(br_x < 0 ? -br_x : br_x);
    d_re   = 33'(in_a_re) - 33'(in_b_re);
    d_im   = 33'(in_a_im) - 33'(in_b_im);
    ad_re  = unsigned'(d_re < 0 ? -d_re : d_re);
    ad_im  = unsigned'(d_im < 0 ? -d_im : d_im);
    eq     = 1'b0;
    case (in_action)
      ACT_ADD: begin
        s_re = 66'(in_a_re) + 66'(in_b_re);
        s_im = 66'(in_a_im) + 66'(in_b_im);
      end
      ACT_SUB: begin
        s_re = 66'(in_a_re) - 66'(in_b_re);
        s_im = 66'(in_a_im) - 66'(in_b_im);
      end
      ACT_MUL: begin
        s_re  = 66'(in_p[0]) - 66'(in_p[1]);
        s_im  = 66'(in_p[2]) + 66'(in_p[3]);
        shift = 1'b1;
      end
      ACT_CDIV: begin
        den = unsigned'(in_p[4]) + unsigned'(in_p[5]);
        if (den == '0) begin
          divz = 1'b1;
        end else begin
          s_re   = 66'(in_p[0]) + 66'(in_p[1]);
          s_im   = 66'(in_p[2]) - 66'(in_p[3]);
          is_div = 1'b1;
        end
      end
      ACT_RDIV: begin
        den = DEN_BITS'(abs_br);
        if (in_b_re == '0) begin
          divz = 1'b1;
        end else begin
          s_re   = 66'(in_a_re);
          s_im   = 66'(in_a_im);
          is_div = 1'b1;
        end
      end
      ACT_CONJ: begin
        s_re = 66'(in_a_re);
        s_im = -66'(in_a_im);
      end
      ACT_MODSQ: begin
        s_re  = 66'(in_p[4]) + 66'(in_p[5]);
        shift = 1'b1;
      end
      ACT_CMP: begin
        eq = (ad_re < 33'(tolerance)) && (ad_im < 33'(tolerance));
      end
      default: begin
        s_re = '0;
      end
    endcase
    m_re   = unsigned'(s_re < 0 ? -s_re : s_re);
    m_im   = unsigned'(s_im < 0 ? -s_im : s_im);
    neg_re = s_re < 0;
    neg_im = s_im < 0;
    if (in_action == ACT_RDIV) begin
      neg_re = neg_re ^ in_b_re[31];
      neg_im = neg_im ^ in_b_re[31];
    end
  end

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      f1_r     <= '{is_div: is_div, divz: divz, eq: eq, neg_re: neg_re,
                    neg_im: neg_im, ovf_re: 1'b0, ovf_im: 1'b0};
      shift1_r <= shift;
      mag_re_r <= m_re[64:0];
      mag_im_r <= m_im[64:0];
      den1_r   <= den;
    end
  end

  always_comb begin
    den_sh = XW'(den1_r) << QW;
    if (f1_r.is_div) begin
      r_re = XW'(mag_re_r) << FRAC_BITS;
      r_im = XW'(mag_im_r) << FRAC_BITS;
    end else if (shift1_r) begin
      r_re = XW'(mag_re_r >> FRAC_BITS);
      r_im = XW'(mag_im_r >> FRAC_BITS);
    end else begin
      r_re = XW'(mag_re_r);
      r_im = XW'(mag_im_r);
    end
    f2_nxt        = f1_r;
    f2_nxt.ovf_re = f1_r.is_div && (r_re >= den_sh);
    f2_nxt.ovf_im = f1_r.is_div && (r_im >= den_sh);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      f2_r     <= f2_nxt;
      rem_re_r <= r_re;
      rem_im_r <= r_im;
      den2_r   <= den1_r;
    end
  end

  assign out_valid  = v2_r;
  assign out_flags  = f2_r;
  assign out_rem_re = rem_re_r;
  assign out_rem_im = rem_im_r;
  assign out_den    = den2_r;

endmodule

// ===== src/cfpa_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_div_cell
// One restoring-division cell: settles one quotient bit of both parts.
// ----------------------------------------------------------------------------
module cfpa_div_cell
  import cfpa_pkg::*;
#(
  parameter int XW  = 97,
  parameter int QW  = 33,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  flags_t              in_flags,
  input  logic [XW-1:0]       in_rem_re,
  input  logic [XW-1:0]       in_rem_im,
  input  logic [QW-1:0]       in_q_re,
  input  logic [QW-1:0]       in_q_im,
  input  logic [DEN_BITS-1:0] in_den,
  output logic                out_valid,
  input  logic                out_ready,
  output flags_t              out_flags,
  output logic [XW-1:0]       out_rem_re,
  output logic [XW-1:0]       out_rem_im,
  output logic [QW-1:0]       out_q_re,
  output logic [QW-1:0]       out_q_im,
  output logic [DEN_BITS-1:0] out_den
);

  logic                valid_r;
  flags_t              flags_r;
  logic [XW-1:0]       rem_re_r, rem_im_r, rem_re_nxt, rem_im_nxt, dsh;
  logic [QW-1:0]       q_re_r, q_im_r, q_re_nxt, q_im_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic                take_re, take_im;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    dsh        = XW'(in_den) << BIT;
    take_re    = in_flags.is_div && !in_flags.ovf_re && (in_rem_re >= dsh);
    take_im    = in_flags.is_div && !in_flags.ovf_im && (in_rem_im >= dsh);
    rem_re_nxt = take_re ? in_rem_re - dsh : in_rem_re;
    rem_im_nxt = take_im ? in_rem_im - dsh : in_rem_im;
    q_re_nxt   = in_q_re;
    q_im_nxt   = in_q_im;
    q_re_nxt[BIT] = take_re;
    q_im_nxt[BIT] = take_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      flags_r  <= in_flags;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      den_r    <= in_den;
    end
  end

  assign out_valid  = valid_r;
  assign out_flags  = flags_r;
  assign out_rem_re = rem_re_r;
  assign out_rem_im = rem_im_r;
  assign out_q_re   = q_re_r;
  assign out_q_im   = q_im_r;
  assign out_den    = den_r;

endmodule

// ===== src/cfpa_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_out
// Last pipeline cell: saturates both parts, sets the status and holds the
// result until it is transferred.
// ----------------------------------------------------------------------------
module cfpa_out
  import cfpa_pkg::*;
#(
  parameter int XW       = 97,
  parameter int QW       = 33,
  parameter int RES_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  flags_t        in_flags,
  input  logic [XW-1:0] in_rem_re,
  input  logic [XW-1:0] in_rem_im,
  input  logic [QW-1:0] in_q_re,
  input  logic [QW-1:0] in_q_im,
  cfpa_out_if.source    out_ch
);

  localparam logic [XW-1:0] LIM = (XW'(1) << (RES_BITS - 1)) - XW'(1);

  logic                       valid_r, equal_r;
  logic signed [31:0]         re_r, im_r;
  logic [1:0]                 status_r, status_nxt;
  logic [XW-1:0]              mag_re, mag_im;
  logic                       sat_re, sat_im;
  logic signed [RES_BITS-1:0] v_re, v_im;

  function automatic logic signed [RES_BITS-1:0] clamp(input logic neg,
                                                       input logic sat,
                                                       input logic [XW-1:0] mag);
    logic signed [RES_BITS-1:0] lo;
    lo = signed'(mag[RES_BITS-1:0]);
    if (sat) begin
      clamp = neg ? signed'({1'b1, {(RES_BITS - 1){1'b0}}})
                  : signed'({1'b0, {(RES_BITS - 1){1'b1}}});
    end else begin
      clamp = neg ? -lo : lo;
    end
  endfunction

  assign in_ready = !valid_r || out_ch.ready;

  always_comb begin
    mag_re = in_flags.is_div ? XW'(in_q_re) : in_rem_re;
    mag_im = in_flags.is_div ? XW'(in_q_im) : in_rem_im;
    sat_re = in_flags.ovf_re ||
             (in_flags.neg_re ? (mag_re > LIM + XW'(1)) : (mag_re > LIM));
    sat_im = in_flags.ovf_im ||
             (in_flags.neg_im ? (mag_im > LIM + XW'(1)) : (mag_im > LIM));
    v_re   = clamp(in_flags.neg_re, sat_re, mag_re);
    v_im   = clamp(in_flags.neg_im, sat_im, mag_im);
    if (in_flags.divz) begin
      status_nxt = ST_DIVZ;
    end else if (sat_re || sat_im) begin
      status_nxt = ST_SAT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      re_r     <= 32'(v_re);
      im_r     <= 32'(v_im);
      equal_r  <= in_flags.eq;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = valid_r;
  assign out_ch.res_re = re_r;
  assign out_ch.res_im = im_r;
  assign out_ch.equal  = equal_r;
  assign out_ch.status = status_r;

endmodule
